// ===== sv/dsa_pkg.sv =====
// Shared types and constants for the dense handle slot allocator.
// No dependencies; imported by dsa_ctrl, dsa_datapath and the top level.
package dsa_pkg;

   // Table depth: number of handles and of dense slots.
   localparam int MAX_ENTRIES = 64;
   // Address width into the tables.
   localparam int INDEX_W = $clog2(MAX_ENTRIES);
   // Counter width: holds 0 .. MAX_ENTRIES.
   localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
   // Port width of handle and slot fields.
   localparam int FIELD_W = 6;
   localparam int STATUS_W = 2;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_INVALID = 2'd2
   } dsa_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_COMMIT
   } dsa_state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;  // latch request, launch table reads
      logic commit;   // apply table updates, register result
   } dsa_cmd_type;

endpackage

// ===== sv/dsa_ctrl.sv =====
// Controller for the dense handle slot allocator: two-state sequencer.
// Depends on dsa_pkg.
module dsa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output dsa_pkg::dsa_cmd_type cmd
);
   import dsa_pkg::*;

   dsa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      busy        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            busy       = 1'b1;
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/dsa_datapath.sv =====
// Datapath for the dense handle slot allocator: map memories, free stack,
// live bits, counters and the registered result. Depends on dsa_pkg.
module dsa_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  dsa_pkg::dsa_cmd_type        cmd,
   input  logic                        req_operation,
   input  logic [dsa_pkg::FIELD_W-1:0] req_release_handle,
   output logic                        rsp_valid,
   output logic [dsa_pkg::FIELD_W-1:0] rsp_handle,
   output logic [dsa_pkg::FIELD_W-1:0] rsp_dense_index,
   output logic [dsa_pkg::FIELD_W-1:0] rsp_moved_handle,
   output logic                        rsp_moved_valid,
   output logic [dsa_pkg::STATUS_W-1:0] rsp_status
);
   import dsa_pkg::*;

   // Memories (contents undefined until written)
   logic [INDEX_W-1:0] h2i_mem_ff [MAX_ENTRIES];
   logic [INDEX_W-1:0] i2h_mem_ff [MAX_ENTRIES];
   logic [INDEX_W-1:0] fs_mem_ff  [MAX_ENTRIES];

   logic [INDEX_W-1:0] h2i_rd_ff, i2h_rd_ff, fs_rd_ff;
   logic [INDEX_W-1:0] h2i_rd_addr, i2h_rd_addr, fs_rd_addr;

   logic               h2i_we, i2h_we, fs_we;
   logic [INDEX_W-1:0] h2i_wr_addr, h2i_wr_data;
   logic [INDEX_W-1:0] i2h_wr_addr, i2h_wr_data;
   logic [INDEX_W-1:0] fs_wr_addr, fs_wr_data;

   logic [MAX_ENTRIES-1:0] live_ff, live_in;
   logic [COUNT_W-1:0]     live_count_ff, live_count_in;
   logic [COUNT_W-1:0]     free_count_ff, free_count_in;
   logic [COUNT_W-1:0]     issued_count_ff, issued_count_in;

   logic               op_ff;
   logic [FIELD_W-1:0] handle_ff;

   logic                rsp_valid_ff;
   logic [FIELD_W-1:0]  res_handle_ff, res_handle_in;
   logic [FIELD_W-1:0]  res_index_ff, res_index_in;
   logic [FIELD_W-1:0]  res_moved_ff, res_moved_in;
   logic                res_mv_ff, res_mv_in;
   dsa_status_type      res_status_ff, res_status_in;

   logic [INDEX_W-1:0] last_slot;
   logic [INDEX_W-1:0] new_handle;
   logic [INDEX_W-1:0] rel_handle;
   logic               rel_ok;

   // Read addresses come from current counts and the incoming request.
   assign h2i_rd_addr = INDEX_W'(req_release_handle);
   assign i2h_rd_addr = INDEX_W'(live_count_ff - COUNT_W'(1));
   assign fs_rd_addr  = INDEX_W'(free_count_ff - COUNT_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         h2i_rd_ff <= h2i_mem_ff[h2i_rd_addr];
         i2h_rd_ff <= i2h_mem_ff[i2h_rd_addr];
         fs_rd_ff  <= fs_mem_ff[fs_rd_addr];
         op_ff     <= req_operation;
         handle_ff <= req_release_handle;
      end
      if (h2i_we) begin
         h2i_mem_ff[h2i_wr_addr] <= h2i_wr_data;
      end
      if (i2h_we) begin
         i2h_mem_ff[i2h_wr_addr] <= i2h_wr_data;
      end
      if (fs_we) begin
         fs_mem_ff[fs_wr_addr] <= fs_wr_data;
      end
   end

   assign last_slot  = INDEX_W'(live_count_ff - COUNT_W'(1));
   assign rel_handle = INDEX_W'(handle_ff);
   assign new_handle = (free_count_ff != '0) ? fs_rd_ff : INDEX_W'(issued_count_ff);
   assign rel_ok     = (32'(handle_ff) < 32'(MAX_ENTRIES)) && live_ff[rel_handle] &&
                       (live_count_ff != '0);

   always_comb begin
      live_in         = live_ff;
      live_count_in   = live_count_ff;
      free_count_in   = free_count_ff;
      issued_count_in = issued_count_ff;
      h2i_we          = 1'b0;
      i2h_we          = 1'b0;
      fs_we           = 1'b0;
      h2i_wr_addr     = new_handle;
      h2i_wr_data     = INDEX_W'(live_count_ff);
      i2h_wr_addr     = INDEX_W'(live_count_ff);
      i2h_wr_data     = new_handle;
      fs_wr_addr      = INDEX_W'(free_count_ff);
      fs_wr_data      = rel_handle;
      res_handle_in   = '0;
      res_index_in    = '0;
      res_moved_in    = '0;
      res_mv_in       = 1'b0;
      res_status_in   = STATUS_OK;

      if (op_ff == OP_ALLOC) begin
         if ((live_count_ff >= COUNT_W'(MAX_ENTRIES)) ||
             ((free_count_ff == '0) && (issued_count_ff >= COUNT_W'(MAX_ENTRIES)))) begin
            res_status_in = STATUS_FULL;
         end else begin
            res_handle_in = FIELD_W'(new_handle);
            res_index_in  = FIELD_W'(live_count_ff);
            if (cmd.commit) begin
               h2i_we              = 1'b1;
               i2h_we              = 1'b1;
               live_in[new_handle] = 1'b1;
               live_count_in       = live_count_ff + COUNT_W'(1);
               if (free_count_ff != '0) begin
                  free_count_in = free_count_ff - COUNT_W'(1);
               end else begin
                  issued_count_in = issued_count_ff + COUNT_W'(1);
               end
            end
         end
      end else begin
         res_handle_in = handle_ff;
         if (!rel_ok) begin
            res_status_in = STATUS_INVALID;
         end else begin
            res_index_in = FIELD_W'(h2i_rd_ff);
            // Last slot moves into the hole unless the hole is the last slot.
            if (h2i_rd_ff != last_slot) begin
               res_moved_in = FIELD_W'(i2h_rd_ff);
               res_mv_in    = 1'b1;
            end
            h2i_wr_addr = i2h_rd_ff;
            h2i_wr_data = h2i_rd_ff;
            i2h_wr_addr = h2i_rd_ff;
            i2h_wr_data = i2h_rd_ff;
            if (cmd.commit) begin
               h2i_we              = res_mv_in;
               i2h_we              = res_mv_in;
               live_in[rel_handle] = 1'b0;
               live_count_in       = live_count_ff - COUNT_W'(1);
               if (free_count_ff < COUNT_W'(MAX_ENTRIES)) begin
                  fs_we         = 1'b1;
                  free_count_in = free_count_ff + COUNT_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff         <= '0;
         live_count_ff   <= '0;
         free_count_ff   <= '0;
         issued_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         live_ff         <= live_in;
         live_count_ff   <= live_count_in;
         free_count_ff   <= free_count_in;
         issued_count_ff <= issued_count_in;
         rsp_valid_ff    <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_handle_ff <= res_handle_in;
         res_index_ff  <= res_index_in;
         res_moved_ff  <= res_moved_in;
         res_mv_ff     <= res_mv_in;
         res_status_ff <= res_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_handle       = res_handle_ff;
   assign rsp_dense_index  = res_index_ff;
   assign rsp_moved_handle = res_moved_ff;
   assign rsp_moved_valid  = res_mv_ff;
   assign rsp_status       = res_status_ff;

endmodule

// ===== sv/dense_handle_slot_allocator.sv =====
// Dense handle slot allocator (slot map with free stack), top level.
// Accept moves to the commit state, which registers the result and its strobe;
// no new start is taken during that read-then-update pass over the map memories.
// A new start is taken in the cycle that shows the previous result.
// Synchronous reset empties the tables (live bits, counts); maps need none.
// The receiver cannot stall: each result shows for exactly one cycle.
module dense_handle_slot_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_operation,
   input  logic [dsa_pkg::FIELD_W-1:0]  req_release_handle,
   output logic                         rsp_valid,
   output logic [dsa_pkg::FIELD_W-1:0]  rsp_handle,
   output logic [dsa_pkg::FIELD_W-1:0]  rsp_dense_index,
   output logic [dsa_pkg::FIELD_W-1:0]  rsp_moved_handle,
   output logic                         rsp_moved_valid,
   output logic [dsa_pkg::STATUS_W-1:0] rsp_status
);
   import dsa_pkg::*;

   // Commands from the sequencer: capture on accept, commit in the cycle after.
   dsa_cmd_type cmd;

   // Sequencer: idle -> commit -> idle.
   dsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Tables and result register. Allocate pops the free stack or issues
   // the next fresh handle; release swaps the last dense entry into the hole.
   dsa_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_operation      (req_operation),
      .req_release_handle (req_release_handle),
      .rsp_valid          (rsp_valid),
      .rsp_handle         (rsp_handle),
      .rsp_dense_index    (rsp_dense_index),
      .rsp_moved_handle   (rsp_moved_handle),
      .rsp_moved_valid    (rsp_moved_valid),
      .rsp_status         (rsp_status)
   );

endmodule
